[hdl/life_grid_step_led_map_unit_defines.svh]
// ----------------------------------------------------------------------------
// life grid step led map unit defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_STEP_LED_MAP_UNIT_DEFINES_SVH
`define LIFE_GRID_STEP_LED_MAP_UNIT_DEFINES_SVH

// clocked assertion, off while reset is low
`define LGS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define LGS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// operation codes and field widths of the life grid led map unit
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 3;
  localparam int unsigned BRIGHT_W   = 12;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned CHANNELS_PER_CELL = 3;

  typedef enum logic [OP_W-1:0] {
    OP_STEP   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_INVERT = 2'd2
  } lgs_op_e;

endpackage

[hdl/life_grid_step_led_map_unit.sv]
// step: row scan over the grid, then a read of the first row, then one led result per
//   cycle while the output is not stalled (GRID_SIZE*GRID_SIZE results); an unchanged
//   step runs an invert pass and one acknowledge; toggle reads and writes one row
// one request at a time; the row memory has a single read port
// reset: row valid flags clear at once so the grid reads all dead, no sweep
// ----------------------------------------------------------------------------
// life_grid_step_led_map_unit
// conway grid held as one row per memory word, with led channel mapping
// ----------------------------------------------------------------------------
module life_grid_step_led_map_unit #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // row [2:0], column [5:3], brightness [17:6]
  input  logic [lgs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation [1:0]
  input  logic [lgs_pkg::OP_W-1:0]          s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // led_channel [7:0], pwm_value [19:8]
  output logic [lgs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // changed [0]
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [lgs_pkg::COLOR_W-1:0]       cfg_data_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o
);

  localparam int unsigned AW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(GRID_SIZE + 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_INV,
    ST_TGL_RD,
    ST_TGL_WR,
    ST_ACK
  } state_e;

  state_e                          state_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [GRID_SIZE-1:0]            above_q;
  logic [GRID_SIZE-1:0]            mid_q;
  logic                            any_q;
  logic [AW-1:0]                   erow_q;
  logic [AW-1:0]                   ecol_q;
  logic [AW-1:0]                   trow_q;
  logic [AW-1:0]                   tcol_q;
  logic [lgs_pkg::BRIGHT_W-1:0]    bright_q;
  logic [lgs_pkg::COLOR_W-1:0]     color_q;

  logic                            out_valid_q;
  logic [lgs_pkg::CHAN_W-1:0]      out_chan_q;
  logic [lgs_pkg::BRIGHT_W-1:0]    out_pwm_q;
  logic                            out_chg_q;
  logic                            out_last_q;

  logic [GRID_SIZE-1:0]            grid_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0]            row_valid_q;
  logic [GRID_SIZE-1:0]            rd_q;

  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [GRID_SIZE-1:0]            mem_wdata;

  logic                            in_req;
  logic                            slot;
  logic                            out_load;
  logic                            in_grid;
  logic [CNT_W-1:0]                cnt_m1;
  logic [CNT_W-1:0]                cnt_m2;
  logic [GRID_SIZE-1:0]            below;
  logic [GRID_SIZE-1:0]            gen_row;
  logic                            gen_chg;
  logic [lgs_pkg::CHAN_W-1:0]      cell_idx;
  logic [lgs_pkg::CHAN_W-1:0]      led_chan;
  logic                            emit_row_end;
  logic                            emit_last;

  assign in_req      = s_axis_tvalid && s_axis_tready;
  assign slot        = !out_valid_q || m_axis_tready;
  assign out_load    = slot && ((state_q == ST_EMIT) || (state_q == ST_ACK));
  assign cfg_ready_o = 1'b1;

  assign in_grid = ({1'b0, s_axis_tdata[2:0]} < 4'(GRID_SIZE))
                && ({1'b0, s_axis_tdata[5:3]} < 4'(GRID_SIZE));

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);

  // incoming row is valid while the scan still reads grid rows
  assign below = ((cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(GRID_SIZE))) ? rd_q : '0;

  lgs_row_rule #(
    .GRID_SIZE (GRID_SIZE)
  ) u_row_rule (
    .above_i   (above_q),
    .mid_i     (mid_q),
    .below_i   (below),
    .next_o    (gen_row),
    .changed_o (gen_chg)
  );

  assign cell_idx     = lgs_pkg::CHAN_W'(erow_q) * lgs_pkg::CHAN_W'(GRID_SIZE)
                      + lgs_pkg::CHAN_W'(ecol_q);
  assign led_chan     = cell_idx * lgs_pkg::CHAN_W'(lgs_pkg::CHANNELS_PER_CELL)
                      + lgs_pkg::CHAN_W'(color_q);
  assign emit_row_end = (ecol_q == AW'(GRID_SIZE - 1));
  assign emit_last    = emit_row_end && (erow_q == AW'(GRID_SIZE - 1));

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state_q)
      ST_GEN: begin
        mem_re    = (cnt_q < CNT_W'(GRID_SIZE));
        mem_raddr = cnt_q[AW-1:0];
        mem_we    = (cnt_q >= CNT_W'(2));
        mem_waddr = cnt_m2[AW-1:0];
        mem_wdata = gen_row;
      end
      ST_INV: begin
        mem_re    = (cnt_q < CNT_W'(GRID_SIZE));
        mem_raddr = cnt_q[AW-1:0];
        mem_we    = (cnt_q >= CNT_W'(1));
        mem_waddr = cnt_m1[AW-1:0];
        mem_wdata = ~rd_q;
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = erow_q;
      end
      ST_EMIT: begin
        // prefetch the next row while the last column goes out
        mem_re    = slot && emit_row_end && !emit_last;
        mem_raddr = erow_q + AW'(1);
      end
      ST_TGL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = trow_q;
      end
      ST_TGL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = trow_q;
        mem_wdata = rd_q ^ (GRID_SIZE'(1) << tcol_q);
      end
      default: begin
      end
    endcase
  end

  // row memory, unwritten rows read as dead
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= row_valid_q[mem_raddr] ? grid_mem[mem_raddr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (mem_we) begin
      row_valid_q[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      any_q       <= 1'b0;
      erow_q      <= '0;
      ecol_q      <= '0;
      out_valid_q <= 1'b0;
      above_q     <= '0;
      mid_q       <= '0;
      trow_q      <= '0;
      tcol_q      <= '0;
      bright_q    <= '0;
      out_chan_q  <= '0;
      out_pwm_q   <= '0;
      out_chg_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            trow_q   <= s_axis_tdata[AW-1:0];
            tcol_q   <= s_axis_tdata[3+AW-1:3];
            bright_q <= s_axis_tdata[17:6];
            cnt_q    <= '0;
            above_q  <= '0;
            mid_q    <= '0;
            any_q    <= 1'b0;
            case (s_axis_tuser)
              lgs_pkg::OP_STEP:   state_q <= ST_GEN;
              lgs_pkg::OP_TOGGLE: state_q <= in_grid ? ST_TGL_RD : ST_ACK;
              lgs_pkg::OP_INVERT: state_q <= ST_INV;
              default:            state_q <= ST_ACK;
            endcase
          end
        end
        ST_GEN: begin
          if (cnt_q >= CNT_W'(1)) begin
            above_q <= mid_q;
            mid_q   <= below;
          end
          if (cnt_q >= CNT_W'(2)) begin
            any_q <= any_q || gen_chg;
          end
          if (cnt_q == CNT_W'(GRID_SIZE + 1)) begin
            cnt_q  <= '0;
            erow_q <= '0;
            ecol_q <= '0;
            state_q <= (any_q || gen_chg) ? ST_EMIT_RD : ST_INV;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot) begin
            out_chan_q  <= led_chan;
            out_pwm_q   <= rd_q[ecol_q] ? bright_q : '0;
            out_chg_q   <= 1'b1;
            out_last_q  <= emit_last;
            if (emit_row_end) begin
              ecol_q <= '0;
              if (emit_last) begin
                state_q <= ST_IDLE;
              end else begin
                erow_q <= erow_q + AW'(1);
              end
            end else begin
              ecol_q <= ecol_q + AW'(1);
            end
          end
        end
        ST_INV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(GRID_SIZE)) begin
            state_q <= ST_ACK;
          end
        end
        ST_TGL_RD: begin
          state_q <= ST_TGL_WR;
        end
        ST_TGL_WR: begin
          state_q <= ST_ACK;
        end
        ST_ACK: begin
          if (slot) begin
            out_chan_q  <= '0;
            out_pwm_q   <= '0;
            out_chg_q   <= 1'b0;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_pwm_q, out_chan_q};
  assign m_axis_tuser  = out_chg_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/lgs_row_rule.sv]
// ----------------------------------------------------------------------------
// lgs_row_rule
// next generation of one grid row from the old rows above, at and below it
// ----------------------------------------------------------------------------
module lgs_row_rule #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic [GRID_SIZE-1:0] above_i,
  input  logic [GRID_SIZE-1:0] mid_i,
  input  logic [GRID_SIZE-1:0] below_i,
  output logic [GRID_SIZE-1:0] next_o,
  output logic                 changed_o
);

  logic [GRID_SIZE+1:0] pad_a;
  logic [GRID_SIZE+1:0] pad_m;
  logic [GRID_SIZE+1:0] pad_b;
  logic [3:0]           nbr [GRID_SIZE];

  // dead border on both sides
  assign pad_a = {1'b0, above_i, 1'b0};
  assign pad_m = {1'b0, mid_i, 1'b0};
  assign pad_b = {1'b0, below_i, 1'b0};

  always_comb begin
    for (int c = 0; c < GRID_SIZE; c++) begin
      nbr[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
             + 4'(pad_m[c]) + 4'(pad_m[c+2])
             + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
      next_o[c] = (nbr[c] == 4'd3) || (mid_i[c] && (nbr[c] == 4'd2));
    end
  end

  assign changed_o = (next_o != mid_i);

endmodule

[hdl/lgs_checker.sv]
// ----------------------------------------------------------------------------
// lgs_checker
// port level checks of the life grid led map unit, bound to the top level
// ----------------------------------------------------------------------------
`include "life_grid_step_led_map_unit_defines.svh"

module lgs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [lgs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);

  // stalled result holds
  `LGS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // acknowledge and unchanged results are single, empty and last
  `LGS_ASSERT(a_ack_form, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0), "malformed acknowledge")

  // a request is worked on before the next one is taken
  `LGS_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

  // nothing offered during reset
  `LGS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")

endmodule

bind life_grid_step_led_map_unit lgs_checker u_lgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives life grid requests and color settings into the led map unit and
// checks every led result against a cycle-free model of the grid
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned GRID        = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [7:0]  chan;
    logic [11:0] pwm;
    logic        chg;
    logic        last;
  } led_result_t;

  class life_led_tracker;
    bit [GRID*GRID-1:0] grid;
    logic [1:0]         color;
    led_result_t        pending[$];
    int unsigned        faults;

    function new();
      grid   = '0;
      color  = '0;
      faults = 0;
    endfunction

    function bit live_at(int r, int c);
      if (r < 0 || c < 0 || r >= GRID || c >= GRID) return 1'b0;
      return grid[r*GRID+c];
    endfunction

    // note an accepted request and queue the led results it causes
    function void apply_request(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                logic [11:0] bright);
      bit [GRID*GRID-1:0] next;
      int                 n;
      bit                 scan_out;
      led_result_t        res;
      scan_out = 1'b0;
      case (op)
        lgs_pkg::OP_STEP: begin
          for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
              n = 0;
              for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc);
              next[r*GRID+c] = grid[r*GRID+c] ? (n == 2 || n == 3) : (n == 3);
            end
          end
          if (next != grid) begin
            grid     = next;
            scan_out = 1'b1;
            for (int idx = 0; idx < GRID*GRID; idx++) begin
              res.chan = 8'(idx * lgs_pkg::CHANNELS_PER_CELL + color);
              res.pwm  = grid[idx] ? bright : 12'd0;
              res.chg  = 1'b1;
              res.last = (idx == GRID*GRID-1);
              pending.push_back(res);
            end
          end else begin
            grid = ~grid;
          end
        end
        lgs_pkg::OP_TOGGLE: begin
          if (row < GRID && col < GRID) grid[row*GRID+col] = ~grid[row*GRID+col];
        end
        lgs_pkg::OP_INVERT: begin
          grid = ~grid;
        end
        default: begin
        end
      endcase
      if (!scan_out) begin
        res = '{chan: 8'd0, pwm: 12'd0, chg: 1'b0, last: 1'b1};
        pending.push_back(res);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        faults++;
      end
    endfunction

    function void match_led(logic [7:0] chan, logic [11:0] pwm, logic chg, logic last);
      led_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected led result, expected none actual chan %0d pwm %0d chg %0b last %0b",
                 $time, chan, pwm, chg, last);
        faults++;
        return;
      end
      want = pending.pop_front();
      check_field("led_channel", want.chan, chan);
      check_field("pwm_value", want.pwm, pwm);
      check_field("changed", want.chg, chg);
      check_field("last", want.last, last);
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni;
  logic [lgs_pkg::IN_DATA_W-1:0]     s_axis_tdata  = '0;
  logic [lgs_pkg::OP_W-1:0]          s_axis_tuser  = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [lgs_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic [0:0]                        m_axis_tuser;
  logic                              m_axis_tlast;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [lgs_pkg::COLOR_W-1:0]       cfg_data_i    = '0;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;

  life_led_tracker tracker = new();
  int unsigned     sent_count = 0;
  int unsigned     idle_cycles = 0;
  bit              calm = 1'b0;

  life_grid_step_led_map_unit #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.match_led(m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tuser[0], m_axis_tlast);
    end
  end

  // stall watchdog, any handshake on the request, result or color port restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                           logic [11:0] bright);
    while (!calm && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {6'd0, bright, col, row};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_request(op, row, col, bright);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_color(logic [1:0] color);
    wait_drained();
    cfg_data_i  <= color;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.color = color;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small seeded patterns followed by a few generations
  task automatic run_random(int unsigned target);
    int unsigned pick;
    int unsigned r0;
    int unsigned c0;
    int          offs[$];
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        r0 = $urandom_range(GRID-1);
        c0 = $urandom_range(GRID-1);
        case ($urandom_range(3))
          0: offs = '{0, 1, 2};
          1: offs = '{1, 10, 16, 17, 18};
          2: offs = '{0, 1, 8, 9};
          default: begin
            offs = {};
            repeat ($urandom_range(3, 6)) offs.push_back($urandom_range(2) * 8 + $urandom_range(2));
          end
        endcase
        foreach (offs[k]) begin
          send_item(lgs_pkg::OP_TOGGLE, 3'((r0 + offs[k] / 8) % GRID),
                    3'((c0 + offs[k] % 8) % GRID), 12'($urandom_range(4095)));
        end
        repeat ($urandom_range(1, 6)) begin
          send_item(lgs_pkg::OP_STEP, 3'($urandom_range(7)), 3'($urandom_range(7)),
                    12'($urandom_range(4095)));
        end
      end else if (pick < 70) begin
        send_item(lgs_pkg::OP_INVERT, 3'($urandom_range(7)), 3'($urandom_range(7)),
                  12'($urandom_range(4095)));
        send_item(lgs_pkg::OP_STEP, 3'($urandom_range(7)), 3'($urandom_range(7)),
                  12'($urandom_range(4095)));
      end else begin
        send_item(2'($urandom_range(3)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                  12'($urandom_range(4095)));
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty grid is still, so the step inverts it
    send_item(lgs_pkg::OP_STEP, 3'd0, 3'd0, 12'd4095);
    send_item(lgs_pkg::OP_INVERT, 3'd7, 3'd7, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd3, 3'd3, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd3, 3'd4, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd4, 3'd3, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd4, 3'd4, 12'd0);
    // still block, inverted around it
    send_item(lgs_pkg::OP_STEP, 3'd0, 3'd0, 12'd4095);
    send_item(lgs_pkg::OP_INVERT, 3'd0, 3'd0, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd3, 3'd3, 12'd0);
    send_item(lgs_pkg::OP_STEP, 3'd0, 3'd0, 12'd4095);
    send_item(OP_UNUSED, 3'd7, 3'd7, 12'd4095);
    send_item(lgs_pkg::OP_TOGGLE, 3'd0, 3'd0, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd7, 3'd7, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd0, 3'd7, 12'd0);
    send_item(lgs_pkg::OP_TOGGLE, 3'd7, 3'd0, 12'd0);
    send_item(lgs_pkg::OP_STEP, 3'd7, 3'd7, 12'd0);
    send_item(lgs_pkg::OP_INVERT, 3'd0, 3'd0, 12'd0);
    send_item(lgs_pkg::OP_STEP, 3'd5, 3'd2, 12'hA5A);

    write_color(2'd2);
    run_random(100);
    write_color(2'd3);
    calm = 1'b1;
    run_random(190);
    calm = 1'b0;
    write_color(2'd1);
    run_random(280);
    write_color(2'd0);
    run_random(370);

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (tracker.faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
